@@ hw/rtl/i2cm_pkg.sv @@
// Shared types and constants for the I2C master bit engine.
// Used by the front, back, queue users and the top level; depends on nothing.
`timescale 1ns / 1ps

package i2cm_pkg;

  // Bits in one transferred byte.
  localparam int BITS_PER_BYTE = 8;

  // Index of the last phase of a send: three phases per bit plus the closing SCL low.
  localparam logic [4:0] SEND_LAST_PHASE = 5'(BITS_PER_BYTE * 3);

  // Index of the last phase of start, ack check and stop.
  localparam logic [4:0] SHORT_LAST_PHASE = 5'd2;

  // Half period after reset.
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;

  // Default depth of the internal queues.
  localparam int QUEUE_DEPTH = 4;

  // Command codes.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_SEND  = 2'd1,
    OP_ACK   = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  // One classified tick word handed from the front to the back.
  typedef struct packed {
    logic       cmd_valid;
    op_t        opcode;
    logic [7:0] data_byte;
    logic       sda_in;
    logic       scl_init;
    logic       sda_set;
    logic       sda_init;
    logic       drive_init;
    logic [4:0] last_phase;
  } dec_t;

  // One result word.
  typedef struct packed {
    logic scl;
    logic sda_out;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic ack_seen;
  } result_t;

endpackage

@@ hw/rtl/i2cm_fifo.sv @@
// Small synchronous queue of register entries with full and empty flags.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps

module i2cm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[head];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= ptr_inc(tail);
      end
      if (do_pop) begin
        head <= ptr_inc(head);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= wdata;
    end
  end

endmodule

@@ hw/rtl/i2cm_front.sv @@
// Front end: accepts tick words and classifies any command they carry.
// Depends on i2cm_pkg for the command codes and the classified word type.
`timescale 1ns / 1ps

module i2cm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              cmd_valid,
  input  logic [1:0]        opcode,
  input  logic [7:0]        data_byte,
  input  logic              sda_in,
  output logic              q_push,
  output i2cm_pkg::dec_t    q_data,
  input  logic              q_full
);

  i2cm_pkg::dec_t dec;
  i2cm_pkg::dec_t held;
  logic           valid;
  logic           take;

  // Work out the first phase's pin levels and the last phase index of the command.
  always_comb begin
    dec            = '0;
    dec.cmd_valid  = cmd_valid;
    dec.opcode     = i2cm_pkg::op_t'(opcode);
    dec.data_byte  = data_byte;
    dec.sda_in     = sda_in;
    dec.drive_init = 1'b1;
    dec.last_phase = i2cm_pkg::SHORT_LAST_PHASE;
    unique case (i2cm_pkg::op_t'(opcode))
      i2cm_pkg::OP_START: begin
        dec.scl_init = 1'b1;
        dec.sda_set  = 1'b1;
        dec.sda_init = 1'b1;
      end
      i2cm_pkg::OP_SEND: begin
        dec.last_phase = i2cm_pkg::SEND_LAST_PHASE;
      end
      i2cm_pkg::OP_ACK: begin
        dec.drive_init = 1'b0;
      end
      i2cm_pkg::OP_STOP: begin
        dec.sda_set = 1'b1;
      end
      default: begin
        dec.scl_init = 1'b0;
      end
    endcase
  end

  assign full   = valid && q_full;
  assign take   = push && !full;
  assign q_push = valid;
  assign q_data = held;

  // One holding register in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (!q_full) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= dec;
    end
  end

endmodule

@@ hw/rtl/i2cm_back.sv @@
// Back end: the pin phase sequencer, one classified tick word per step.
// Depends on i2cm_pkg for command codes, word types and byte size.
`timescale 1ns / 1ps

module i2cm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        half_period,
  input  i2cm_pkg::dec_t     item,
  input  logic               item_valid,
  output logic               item_pop,
  input  logic               res_full,
  output logic               res_push,
  output i2cm_pkg::result_t  res
);

  // Position within the three phases of one sent bit.
  typedef enum logic [1:0] {
    SLOT_LOW  = 2'd0,
    SLOT_DATA = 2'd1,
    SLOT_HIGH = 2'd2
  } slot_t;

  i2cm_pkg::op_t active_cmd, active_cmd_next;
  logic          running, running_next;
  logic [4:0]    phase_index, phase_index_next;
  logic [4:0]    last_phase, last_phase_next;
  slot_t         slot, slot_next;
  logic [15:0]   tick_count, tick_count_next;
  logic [7:0]    shift_reg, shift_reg_next;
  logic          scl_level, scl_level_next;
  logic          sda_level, sda_level_next;
  logic          sda_driving, sda_driving_next;
  logic          ack_flag, ack_flag_next;
  logic          done_next;
  logic          go;
  logic [15:0]   hp;
  logic [16:0]   tc;
  logic [4:0]    p;

  assign go       = item_valid && !res_full;
  assign item_pop = go;
  assign res_push = go;
  assign hp       = (half_period == '0) ? 16'd1 : half_period;
  assign tc       = {1'b0, tick_count} + 17'd1;
  assign p        = phase_index + 5'd1;

  // Next state for one tick.
  always_comb begin
    active_cmd_next  = active_cmd;
    running_next     = running;
    phase_index_next = phase_index;
    last_phase_next  = last_phase;
    slot_next        = slot;
    tick_count_next  = tick_count;
    shift_reg_next   = shift_reg;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    sda_driving_next = sda_driving;
    ack_flag_next    = ack_flag;
    done_next        = 1'b0;
    if (running) begin
      if (tc >= {1'b0, hp}) begin
        // Acknowledge is sampled as the SCL-high phase ends.
        if (active_cmd == i2cm_pkg::OP_ACK && phase_index == 5'd1) begin
          ack_flag_next = ~item.sda_in;
        end
        tick_count_next = '0;
        if (phase_index >= last_phase) begin
          running_next = 1'b0;
          done_next    = 1'b1;
        end else begin
          phase_index_next = p;
          slot_next = (slot == SLOT_HIGH) ? SLOT_LOW : slot_t'(slot + 2'd1);
          unique case (active_cmd)
            i2cm_pkg::OP_START: begin
              if (p == 5'd1) begin
                sda_level_next = 1'b0;
              end else begin
                scl_level_next = 1'b0;
              end
            end
            i2cm_pkg::OP_SEND: begin
              if (p >= i2cm_pkg::SEND_LAST_PHASE) begin
                scl_level_next = 1'b0;
              end else begin
                unique case (slot_next)
                  SLOT_LOW: scl_level_next = 1'b0;
                  SLOT_DATA: begin
                    sda_level_next = shift_reg[i2cm_pkg::BITS_PER_BYTE-1];
                    shift_reg_next = {shift_reg[6:0], 1'b0};
                  end
                  SLOT_HIGH: scl_level_next = 1'b1;
                  default:   scl_level_next = scl_level;
                endcase
              end
            end
            i2cm_pkg::OP_ACK: begin
              scl_level_next = (p == 5'd1);
            end
            i2cm_pkg::OP_STOP: begin
              if (p == 5'd1) begin
                scl_level_next = 1'b1;
              end else begin
                sda_level_next = 1'b1;
              end
            end
            default: begin
              scl_level_next = scl_level;
            end
          endcase
        end
      end else begin
        tick_count_next = tc[15:0];
      end
    end else if (item.cmd_valid) begin
      // Idle: take the command and show its first phase at once.
      active_cmd_next  = item.opcode;
      if (item.opcode == i2cm_pkg::OP_SEND) begin
        shift_reg_next = item.data_byte;
      end
      phase_index_next = '0;
      last_phase_next  = item.last_phase;
      slot_next        = SLOT_LOW;
      tick_count_next  = '0;
      running_next     = 1'b1;
      sda_driving_next = item.drive_init;
      scl_level_next   = item.scl_init;
      if (item.sda_set) begin
        sda_level_next = item.sda_init;
      end
    end
  end

  // Result word reflects the state after this tick.
  always_comb begin
    res.scl       = scl_level_next;
    res.sda_out   = sda_level_next;
    res.sda_drive = sda_driving_next;
    res.busy_res  = running_next;
    res.done_res  = done_next;
    res.ack_seen  = ack_flag_next;
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_cmd  <= i2cm_pkg::OP_START;
      running     <= 1'b0;
      phase_index <= '0;
      last_phase  <= '0;
      slot        <= SLOT_LOW;
      tick_count  <= '0;
      shift_reg   <= '0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      sda_driving <= 1'b1;
      ack_flag    <= 1'b0;
    end else if (go) begin
      active_cmd  <= active_cmd_next;
      running     <= running_next;
      phase_index <= phase_index_next;
      last_phase  <= last_phase_next;
      slot        <= slot_next;
      tick_count  <= tick_count_next;
      shift_reg   <= shift_reg_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      sda_driving <= sda_driving_next;
      ack_flag    <= ack_flag_next;
    end
  end

endmodule

@@ hw/rtl/i2c_master_bit_engine_top.sv @@
// I2C master bit engine: one tick word in, one result word out, in order.
// Path: front holding register, middle queue, back-end step, then the result queue.
// Throughput: one word per cycle when no full queue holds the flow back.
// Reset: synchronous; queues empty, bus idle (SCL and SDA high, SDA driven), half period 5.
// Depends on i2cm_pkg, i2cm_front, i2cm_fifo and i2cm_back.
`timescale 1ns / 1ps

module i2c_master_bit_engine_top #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        cmd_valid,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic        sda_in,
  output logic        empty,
  input  logic        pop,
  output logic        scl,
  output logic        sda_out,
  output logic        sda_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic        ack_seen
);

  localparam int DEC_W = $bits(i2cm_pkg::dec_t);
  localparam int RES_W = $bits(i2cm_pkg::result_t);

  logic [15:0]       half_period;
  logic              mid_push;
  i2cm_pkg::dec_t    mid_wdata;
  logic              mid_full;
  logic              mid_empty;
  logic [DEC_W-1:0]  mid_rdata;
  logic              mid_pop;
  logic              res_push;
  i2cm_pkg::result_t res_wdata;
  logic              res_full;
  logic [RES_W-1:0]  res_rdata;
  i2cm_pkg::result_t res_out;

  // Half period register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= i2cm_pkg::HALF_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_period <= cfg_data;
    end
  end

  i2cm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd_valid (cmd_valid),
    .opcode    (opcode),
    .data_byte (data_byte),
    .sda_in    (sda_in),
    .q_push    (mid_push),
    .q_data    (mid_wdata),
    .q_full    (mid_full)
  );

  // Queue between classification and sequencing.
  i2cm_fifo #(
    .WIDTH (DEC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  i2cm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .half_period (half_period),
    .item        (i2cm_pkg::dec_t'(mid_rdata)),
    .item_valid  (!mid_empty),
    .item_pop    (mid_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res_wdata)
  );

  // Result queue towards the consumer.
  i2cm_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out   = i2cm_pkg::result_t'(res_rdata);
  assign scl       = res_out.scl;
  assign sda_out   = res_out.sda_out;
  assign sda_drive = res_out.sda_drive;
  assign busy_res  = res_out.busy_res;
  assign done_res  = res_out.done_res;
  assign ack_seen  = res_out.ack_seen;

endmodule

@@ hw/rtl/i2cm_checker.sv @@
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module i2cm_checker (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input logic scl,
  input logic sda_out,
  input logic sda_drive,
  input logic busy_res,
  input logic done_res,
  input logic ack_seen
);

  // After reset no result word is waiting and the input side is open.
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared after reset");

  // A finishing word never reports the command as still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (!empty && done_res) |-> !busy_res)
    else $error("done and busy shown together");

  // A waiting result word stays put until it is popped.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=>
      (!empty && $stable({scl, sda_out, sda_drive, busy_res, done_res, ack_seen})))
    else $error("waiting result word changed before it was popped");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_checker (.*);
